// ===== rtl/assert_macros.svh =====
// Assertion helpers for the timer core. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property with reset disable.
`define STCA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stca assertion failed");
// Checked property, also evaluated during reset.
`define STCA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stca assertion failed");
`else
`define STCA_ASSERT(lbl, clk, rst, prop)
`define STCA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/stca_pkg.sv =====
`timescale 1ns / 1ps

package stca_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // access status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_OFF = 2'd1;
  localparam logic [1:0] ST_RO      = 2'd2;

  // register byte offsets
  localparam logic [11:0] OFF_CNT_LO = 12'h000;
  localparam logic [11:0] OFF_CNT_HI = 12'h004;
  localparam logic [11:0] OFF_FREQ   = 12'h010;
  localparam logic [11:0] OFF_CMP_LO = 12'h020;
  localparam logic [11:0] OFF_CMP_HI = 12'h024;
  localparam logic [11:0] OFF_TVAL   = 12'h028;
  localparam logic [11:0] OFF_CTL    = 12'h02c;
  localparam logic [11:0] OFF_AI_LO  = 12'h040;
  localparam logic [11:0] OFF_AI_HI  = 12'h044;
  localparam logic [11:0] OFF_RELOAD = 12'h048;
  localparam logic [11:0] OFF_AI_CTL = 12'h04c;
  localparam logic [11:0] OFF_CFG    = 12'h050;
  localparam logic [11:0] OFF_ID_BASE = 12'hFD0;

  localparam logic [31:0] CFG_VALUE = 32'd1;

  typedef enum logic [3:0] {
    R_CNT_LO,
    R_CNT_HI,
    R_FREQ,
    R_CMP_LO,
    R_CMP_HI,
    R_TVAL,
    R_CTL,
    R_AI_LO,
    R_AI_HI,
    R_RELOAD,
    R_AI_CTL,
    R_CFG,
    R_ID,
    R_NONE
  } reg_sel_t;

  typedef struct packed {
    reg_sel_t   sel;
    logic [3:0] id_idx;
  } dec_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  status;
    logic        irq;
  } res_t;

  // peripheral / component ID bytes, one per word from OFF_ID_BASE
  function automatic logic [7:0] id_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h04;
      4'd1:    b = 8'h00;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h00;
      4'd4:    b = 8'hb7;
      4'd5:    b = 8'hb0;
      4'd6:    b = 8'h0b;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h0d;
      4'd9:    b = 8'hf0;
      4'd10:   b = 8'h05;
      4'd11:   b = 8'hb1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/stca_decode.sv =====
`timescale 1ns / 1ps

// Offset decode, done ahead of the input register.
module stca_decode (
  input  logic [11:0]        reg_offset,
  output stca_pkg::dec_t     dec
);

  logic [11:0] id_diff;

  assign id_diff = reg_offset - stca_pkg::OFF_ID_BASE;

  always_comb begin
    dec.id_idx = id_diff[5:2];
    case (reg_offset)
      stca_pkg::OFF_CNT_LO: dec.sel = stca_pkg::R_CNT_LO;
      stca_pkg::OFF_CNT_HI: dec.sel = stca_pkg::R_CNT_HI;
      stca_pkg::OFF_FREQ:   dec.sel = stca_pkg::R_FREQ;
      stca_pkg::OFF_CMP_LO: dec.sel = stca_pkg::R_CMP_LO;
      stca_pkg::OFF_CMP_HI: dec.sel = stca_pkg::R_CMP_HI;
      stca_pkg::OFF_TVAL:   dec.sel = stca_pkg::R_TVAL;
      stca_pkg::OFF_CTL:    dec.sel = stca_pkg::R_CTL;
      stca_pkg::OFF_AI_LO:  dec.sel = stca_pkg::R_AI_LO;
      stca_pkg::OFF_AI_HI:  dec.sel = stca_pkg::R_AI_HI;
      stca_pkg::OFF_RELOAD: dec.sel = stca_pkg::R_RELOAD;
      stca_pkg::OFF_AI_CTL: dec.sel = stca_pkg::R_AI_CTL;
      stca_pkg::OFF_CFG:    dec.sel = stca_pkg::R_CFG;
      default: begin
        // ID window runs to the top of the 4 KB frame, word aligned only
        if (reg_offset >= stca_pkg::OFF_ID_BASE && reg_offset[1:0] == 2'b00) begin
          dec.sel = stca_pkg::R_ID;
        end else begin
          dec.sel = stca_pkg::R_NONE;
        end
      end
    endcase
  end

endmodule

// ===== rtl/stca_regs.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Timer register bank: state update and result for one item per cycle; state updates only while go is high.
module stca_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [1:0]           cmd,
  input  stca_pkg::dec_t       dec,
  input  logic [31:0]          write_data,
  input  logic [63:0]          system_count,
  output stca_pkg::res_t       res
);

  logic [31:0] freq_word;
  logic        ctl_en;
  logic        ctl_mask;
  logic [63:0] compare_value;
  logic [63:0] autoinc_value;
  logic        ai_en;
  logic        ai_clr;
  logic [31:0] reload_value;

  logic [31:0] freq_word_next;
  logic        ctl_en_next;
  logic        ctl_mask_next;
  logic [63:0] compare_value_next;
  logic [63:0] autoinc_value_next;
  logic        ai_en_next;
  logic        ai_clr_next;
  logic [31:0] reload_value_next;

  logic [63:0] reload_sum;
  logic [63:0] tval_sum;
  logic        ai_hit;
  logic        cond;
  logic [31:0] tval_rd;

  assign reload_sum = system_count + {32'd0, reload_value};
  assign tval_sum   = system_count + {{32{write_data[31]}}, write_data};
  assign ai_hit     = system_count >= autoinc_value;
  assign tval_rd    = compare_value[31:0] - system_count[31:0];

  always_comb begin
    freq_word_next     = freq_word;
    ctl_en_next        = ctl_en;
    ctl_mask_next      = ctl_mask;
    compare_value_next = compare_value;
    autoinc_value_next = autoinc_value;
    ai_en_next         = ai_en;
    ai_clr_next        = ai_clr;
    reload_value_next  = reload_value;
    if (go && cmd == stca_pkg::CMD_TICK) begin
      if (ctl_en && ai_en && ai_hit) begin
        ai_clr_next        = 1'b1;
        autoinc_value_next = reload_sum;
      end
    end else if (go && cmd == stca_pkg::CMD_WRITE) begin
      case (dec.sel)
        stca_pkg::R_FREQ:   freq_word_next = write_data;
        stca_pkg::R_CMP_LO: compare_value_next = {compare_value[63:32], write_data};
        stca_pkg::R_CMP_HI: compare_value_next = {write_data, compare_value[31:0]};
        stca_pkg::R_TVAL:   compare_value_next = tval_sum;
        stca_pkg::R_CTL: begin
          ctl_en_next   = write_data[0];
          ctl_mask_next = write_data[1];
          if (!ctl_en && write_data[0] && ai_en) begin
            autoinc_value_next = reload_sum;
          end
        end
        stca_pkg::R_RELOAD: reload_value_next = write_data;
        stca_pkg::R_AI_CTL: begin
          // CLR: writing 0 clears, writing 1 leaves it alone
          ai_en_next  = write_data[0];
          ai_clr_next = ai_clr & write_data[1];
          if (!ai_en && write_data[0] && ctl_en) begin
            autoinc_value_next = reload_sum;
          end
        end
        default: ;
      endcase
    end
  end

  // timer condition after this item, with this item's count
  assign cond = ctl_en_next &&
                (ai_en_next ? ai_clr_next : (system_count >= compare_value_next));

  always_comb begin
    res.rdata  = 32'd0;
    res.status = stca_pkg::ST_OK;
    res.irq    = cond && !ctl_mask_next;
    if (cmd == stca_pkg::CMD_READ) begin
      case (dec.sel)
        stca_pkg::R_CNT_LO: res.rdata = system_count[31:0];
        stca_pkg::R_CNT_HI: res.rdata = system_count[63:32];
        stca_pkg::R_FREQ:   res.rdata = freq_word;
        stca_pkg::R_CMP_LO: res.rdata = compare_value[31:0];
        stca_pkg::R_CMP_HI: res.rdata = compare_value[63:32];
        stca_pkg::R_TVAL:   res.rdata = tval_rd;
        stca_pkg::R_CTL:    res.rdata = {29'd0, cond, ctl_mask, ctl_en};
        stca_pkg::R_AI_LO:  res.rdata = autoinc_value[31:0];
        stca_pkg::R_AI_HI:  res.rdata = autoinc_value[63:32];
        stca_pkg::R_RELOAD: res.rdata = reload_value;
        stca_pkg::R_AI_CTL: res.rdata = {30'd0, ai_clr, ai_en};
        stca_pkg::R_CFG:    res.rdata = stca_pkg::CFG_VALUE;
        stca_pkg::R_ID:     res.rdata = {24'd0, stca_pkg::id_byte(dec.id_idx)};
        default:            res.status = stca_pkg::ST_BAD_OFF;
      endcase
    end else if (cmd == stca_pkg::CMD_WRITE) begin
      case (dec.sel)
        stca_pkg::R_CNT_LO, stca_pkg::R_CNT_HI, stca_pkg::R_AI_LO,
        stca_pkg::R_AI_HI, stca_pkg::R_CFG, stca_pkg::R_ID:
          res.status = stca_pkg::ST_RO;
        stca_pkg::R_NONE:
          res.status = stca_pkg::ST_BAD_OFF;
        default:
          res.status = stca_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_word     <= 32'd0;
      ctl_en        <= 1'b0;
      ctl_mask      <= 1'b0;
      compare_value <= 64'd0;
      autoinc_value <= 64'd0;
      ai_en         <= 1'b0;
      ai_clr        <= 1'b0;
      reload_value  <= 32'd0;
    end else begin
      freq_word     <= freq_word_next;
      ctl_en        <= ctl_en_next;
      ctl_mask      <= ctl_mask_next;
      compare_value <= compare_value_next;
      autoinc_value <= autoinc_value_next;
      ai_en         <= ai_en_next;
      ai_clr        <= ai_clr_next;
      reload_value  <= reload_value_next;
    end
  end

  // CLR is only ever set by an accepted tick
  `STCA_ASSERT(a_clr_by_tick, clk, rst, $rose(ai_clr) |-> $past(go) && $past(cmd) == stca_pkg::CMD_TICK)
  // no item, no change of the auto-increment value
  `STCA_ASSERT(a_ai_hold, clk, rst, !go |=> $stable(autoinc_value))
  // enabling the timer in auto-increment mode reloads from that item's count
  `STCA_ASSERT(a_en_reload, clk, rst, $rose(ctl_en) && ai_en |-> autoinc_value == $past(reload_sum))
  // read-only status only comes from a write
  `STCA_ASSERT(a_ro_on_write, clk, rst, res.status == stca_pkg::ST_RO |-> cmd == stca_pkg::CMD_WRITE)

endmodule

// ===== rtl/system_timer_compare_autoinc_core.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake            | Fields
// ---------+----------------------+----------------------------------------------
// req      | req_valid/req_stall  | cmd, reg_offset, write_data, system_count
// rsp      | rsp_valid/rsp_stall  | read_data, access_status, irq_level
//
// One item per clock sustained while rsp_stall is low. An accepted item passes
// through one input register (holding the decoded offset), then the register
// bank update and result mux feeding the output register, where rsp_valid rises.
// The 64-bit reload add and compare in the register bank set the cycle time.
// rst is synchronous, active high; it clears all timer registers and both stages.
// A stalled result holds in the output register; req_stall only rises when
// the input stage is full and the output register cannot drain.
module system_timer_compare_autoinc_core (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  cmd,
  input  logic [11:0] reg_offset,
  input  logic [31:0] write_data,
  input  logic [63:0] system_count,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_data,
  output logic [1:0]  access_status,
  output logic        irq_level
);

  // input stage
  logic           s1_valid;
  logic [1:0]     s1_cmd;
  stca_pkg::dec_t s1_dec;
  logic [31:0]    s1_wdata;
  logic [63:0]    s1_count;

  stca_pkg::dec_t dec;
  stca_pkg::res_t res;
  logic           fire;   // input stage item executes this cycle

  stca_decode u_decode (
    .reg_offset (reg_offset),
    .dec        (dec)
  );

  // item executes when the output register is empty or being drained
  assign fire      = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_cmd   <= cmd;
      s1_dec   <= dec;
      s1_wdata <= write_data;
      s1_count <= system_count;
    end
  end

  // state updates only when the item executes
  stca_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .go           (fire),
    .cmd          (s1_cmd),
    .dec          (s1_dec),
    .write_data   (s1_wdata),
    .system_count (s1_count),
    .res          (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data     <= res.rdata;
      access_status <= res.status;
      irq_level     <= res.irq;
    end
  end

endmodule
